FILE: rtl/core/fcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcd_pkg
// Shared types and constants of the feedback change detector.
// ----------------------------------------------------------------------------
package fcd_pkg;

    localparam int MODULES_DEF = 64;
    localparam int ID_W        = 12;
    localparam int WORD_W      = 16;
    localparam int PIN_ADDR_W  = 10;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [ID_W-1:0] BASE_ID_RESET = 12'd100;

    // Register index, taken from the word-aligned APB address.
    localparam logic REG_BASE_OBJECT_ID = 1'b0;

    typedef struct packed {
        logic [ID_W-1:0]   object_id;
        logic [WORD_W-1:0] state_word;
    } t_fcd_in;

    typedef struct packed {
        logic [PIN_ADDR_W-1:0] pin_address;
        logic                  occupied;
        logic                  last;
    } t_fcd_out;

endpackage
`default_nettype wire

FILE: rtl/core/fcd_emitter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcd_emitter
// Holds the changed-pin mask of one request and issues one result per
// changed pin, lowest pin first.
// ----------------------------------------------------------------------------
module fcd_emitter
    import fcd_pkg::*;
#(
    parameter int PAIR_W = $clog2(MODULES_DEF / 2)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire logic [PAIR_W-1:0]   i_load_pair,
    input  wire logic [WORD_W-1:0]   i_load_word,
    input  wire logic [WORD_W-1:0]   i_load_mask,
    output      logic                o_free,
    output      logic                o_out_valid,
    input  wire logic                i_out_ready,
    output      t_fcd_out            o_out_res
);

    logic              r_valid;
    logic              n_valid;
    logic [WORD_W-1:0] r_mask;
    logic [WORD_W-1:0] n_mask;
    logic [PAIR_W-1:0] r_pair;
    logic [WORD_W-1:0] r_word;
    logic [3:0]        low_idx;
    logic [WORD_W-1:0] rest_mask;
    logic              is_last;
    logic              out_acc;
    logic [11:0]       addr_sum;

    always_comb begin
        low_idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                low_idx = 4'(i);
            end
        end
    end

    assign rest_mask = r_mask & (r_mask - WORD_W'(1));
    assign is_last   = (rest_mask == '0);
    assign out_acc   = r_valid && i_out_ready;
    assign o_free    = !r_valid || (out_acc && is_last);
    assign addr_sum  = 12'({r_pair, low_idx}) + 12'd1;

    assign o_out_valid           = r_valid;
    assign o_out_res.pin_address = addr_sum[PIN_ADDR_W-1:0];
    assign o_out_res.occupied    = r_word[low_idx];
    assign o_out_res.last        = is_last;

    always_comb begin
        n_valid = r_valid;
        n_mask  = r_mask;
        if (i_load) begin
            n_valid = 1'b1;
            n_mask  = i_load_mask;
        end else if (out_acc) begin
            n_valid = !is_last;
            n_mask  = rest_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_mask <= n_mask;
        if (i_load) begin
            r_pair <= i_load_pair;
            r_word <= i_load_word;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/feedback_change_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// feedback_change_detector
// Change-of-state detector for occupancy feedback modules.
// ----------------------------------------------------------------------------
// Each input request carries an object id and a 16-bit state word for one
// pair of 8-pin modules. The pair is the object id minus the base id set
// through the APB port. Ids below the base or beyond the store are dropped.
// For every pin that differs from the stored state, one result carrying the
// pin address and the new state is issued, low module first and pins in
// ascending order, and last marks the final result of a request.
// The pair states live in a one-port-read, one-port-write memory with a
// registered read; a row valid bit per pair, cleared at reset, makes
// every row read as all free until it is first written, so the block is
// ready right after reset. An accepted request is registered in the
// compare stage, and its first result then in the result stage, before it
// is valid. An item with n changed pins gives n results from the result
// stage; an item without changes skips it, so requests can follow every
// cycle while items with changes find the result stage free. The
// stage that compares against the memory holds one request while results
// wait, so a new request is accepted while the receiver stalls; further requests wait until that stage moves on.
// ----------------------------------------------------------------------------
module feedback_change_detector
    import fcd_pkg::*;
#(
    parameter int MODULES = MODULES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output      logic                  o_in_ready,
    input  wire t_fcd_in               i_in_req,
    output      logic                  o_out_valid,
    input  wire logic                  i_out_ready,
    output      t_fcd_out              o_out_res,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output      logic [APB_DATA_W-1:0] prdata,
    output      logic                  pready
);

    localparam int PAIRS  = MODULES / 2;
    localparam int PAIR_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;

    logic [ID_W-1:0]   r_base_id;
    logic              cfg_we;

    logic [WORD_W-1:0] r_mem [PAIRS];
    logic [PAIRS-1:0]  r_row_valid;
    logic [WORD_W-1:0] r_rd_data;
    logic              r_rd_vld;
    logic              r_fwd;
    logic [WORD_W-1:0] r_fwd_data;

    logic              r_s1_valid;
    logic              r_s1_hit;
    logic [PAIR_W-1:0] r_s1_pair;
    logic [WORD_W-1:0] r_s1_word;

    logic [ID_W:0]     id_diff;
    logic              in_hit;
    logic [PAIR_W-1:0] in_pair;
    logic              in_acc;
    logic [WORD_W-1:0] s1_old;
    logic [WORD_W-1:0] s1_mask;
    logic              s1_adv;
    logic              mem_we;
    logic              em_free;
    logic              em_load;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_BASE_OBJECT_ID);

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_BASE_OBJECT_ID) begin
            prdata = APB_DATA_W'(r_base_id);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_id <= BASE_ID_RESET;
        end else if (cfg_we) begin
            r_base_id <= pwdata[ID_W-1:0];
        end
    end

    assign id_diff = {1'b0, i_in_req.object_id} - {1'b0, r_base_id};
    assign in_hit  = !id_diff[ID_W] && (int'(id_diff[ID_W-1:0]) < PAIRS);
    assign in_pair = id_diff[PAIR_W-1:0];

    assign s1_old  = r_fwd ? r_fwd_data : (r_rd_vld ? r_rd_data : '0);
    assign s1_mask = r_s1_hit ? (s1_old ^ r_s1_word) : '0;
    assign s1_adv  = r_s1_valid && ((s1_mask == '0) || em_free);
    assign em_load = s1_adv && (s1_mask != '0);
    assign mem_we  = s1_adv && r_s1_hit;

    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_s1_pair] <= r_s1_word;
        end
        if (in_acc && in_hit) begin
            r_rd_data <= r_mem[in_pair];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (mem_we) begin
            r_row_valid[r_s1_pair] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
        if (in_acc) begin
            r_s1_hit   <= in_hit;
            r_s1_pair  <= in_pair;
            r_s1_word  <= i_in_req.state_word;
            r_rd_vld   <= r_row_valid[in_pair];
            r_fwd      <= mem_we && (r_s1_pair == in_pair);
            r_fwd_data <= r_s1_word;
        end
    end

    fcd_emitter #(
        .PAIR_W (PAIR_W)
    ) u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (em_load),
        .i_load_pair (r_s1_pair),
        .i_load_word (r_s1_word),
        .i_load_mask (s1_mask),
        .o_free      (em_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res)
    );

    a_s1_pair_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_hit) |-> (int'(r_s1_pair) < PAIRS))
        else $error("accepted pair lies outside the store");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted request did not reach the compare stage");

    a_write_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> r_row_valid[$past(r_s1_pair)])
        else $error("written row is not marked valid");

    a_results_continue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out_res.last) |=> o_out_valid)
        else $error("result sequence ended without last");

endmodule
`default_nettype wire

FILE: bench/feedback_change_detector_test.sv
// ----------------------------------------------------------------------------
// feedback_change_detector_test
// Self-checking bench for the feedback change detector.
// ----------------------------------------------------------------------------
// A queue of occupancy events feeds a bursty driver. Every accepted event is
// run through a local model of the module store, which queues the expected
// pin changes. The result side stalls on its own pattern, and every result is
// checked field by field against the oldest expected change. The base id is
// reprogrammed over APB between phases, including both ends of its range.
// ----------------------------------------------------------------------------
module feedback_change_detector_test
    import fcd_pkg::*;
();

    localparam int STORE_MODULES = MODULES_DEF;
    localparam int STORE_PAIRS   = STORE_MODULES / 2;
    localparam int ID_MAX        = (1 << ID_W) - 1;
    localparam int SPARE_REG     = 1;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 300;
    localparam int IDLE_LIMIT    = 4000;
    localparam int REPORT_LIMIT  = 10;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_fcd_in               i_in_req    = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_fcd_out              o_out_res;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    feedback_change_detector DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_fcd_in     pending_events [$];
    t_fcd_out    expected_changes [$];
    logic [7:0]  module_state [STORE_MODULES];
    logic [7:0]  planned_state [STORE_MODULES];
    logic [ID_W-1:0] base_id = BASE_ID_RESET;

    int events_accepted = 0;
    int events_dropped  = 0;
    int changes_checked = 0;
    int mismatch_count  = 0;
    int config_errors   = 0;
    int base_settings   = 1;

    int          burst_left  = 0;
    int          gap_left    = 0;
    int          hold_left   = 0;
    logic        stall_request = 1'b0;
    logic        stall_taken   = 1'b0;
    logic [15:0] rx_cycle    = '0;
    int          idle_cycles = 0;

    initial begin
        for (int m = 0; m < STORE_MODULES; m++) begin
            module_state[m]  = 8'h00;
            planned_state[m] = 8'h00;
        end
    end

    // Applies one event to the local store and queues the pin changes it causes.
    function automatic void predict_changes(input t_fcd_in event_req);
        int          pair;
        int          total;
        int          seen;
        int          module_index;
        logic [15:0] old_word;
        logic [15:0] diff;
        t_fcd_out    change;
        if (int'(event_req.object_id) < int'(base_id)) begin
            events_dropped++;
            return;
        end
        pair = int'(event_req.object_id) - int'(base_id);
        if (2 * pair + 1 >= STORE_MODULES) begin
            events_dropped++;
            return;
        end
        old_word = {module_state[2 * pair + 1], module_state[2 * pair]};
        diff     = old_word ^ event_req.state_word;
        total    = $countones(diff);
        seen     = 0;
        for (int b = 0; b < WORD_W; b++) begin
            if (diff[b]) begin
                module_index       = 2 * pair + b / 8;
                change.pin_address = PIN_ADDR_W'(module_index * 8 + b % 8 + 1);
                change.occupied    = event_req.state_word[b];
                change.last        = (seen == total - 1);
                expected_changes.push_back(change);
                seen++;
            end
        end
        module_state[2 * pair]     = event_req.state_word[7:0];
        module_state[2 * pair + 1] = event_req.state_word[15:8];
    endfunction

    function automatic void report_change(input string what, input t_fcd_out want,
                                          input t_fcd_out got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("mismatch: %s: want pin %0d occ %0d last %0d, got pin %0d occ %0d last %0d",
                     what, want.pin_address, want.occupied, want.last,
                     got.pin_address, got.occupied, got.last);
        end
    endfunction

    function automatic void check_change(input t_fcd_out got);
        t_fcd_out want;
        if (expected_changes.size() == 0) begin
            report_change("result with no change pending", '0, got);
            return;
        end
        want = expected_changes.pop_front();
        changes_checked++;
        if (got.pin_address !== want.pin_address)
            report_change("pin_address", want, got);
        else if (got.occupied !== want.occupied)
            report_change("occupied", want, got);
        else if (got.last !== want.last)
            report_change("last", want, got);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_changes(i_in_req);
                events_accepted++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_events.size() > 0) begin
                    i_in_req   <= pending_events.pop_front();
                    i_in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_cycle    <= '0;
        end else begin
            rx_cycle <= rx_cycle + 16'd1;
            if (o_out_valid && i_out_ready)
                check_change(o_out_res);
            if (hold_left > 0) begin
                hold_left   <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else if (stall_request && !stall_taken) begin
                stall_taken <= 1'b1;
                hold_left   <= LONG_HOLD;
                i_out_ready <= 1'b0;
            end else begin
                case (rx_cycle[9:8])
                    2'd0: i_out_ready <= 1'b1;
                    2'd1: i_out_ready <= ($urandom_range(0, 9) < 7);
                    2'd2: i_out_ready <= (rx_cycle[1:0] != 2'd3);
                    default: i_out_ready <= rx_cycle[2];
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (pending_events.size() == 0 && !i_in_valid
                    && expected_changes.size() == 0)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: %0d events queued, %0d changes outstanding",
                     pending_events.size(), expected_changes.size());
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Queues one event and tracks what the store will hold once it is taken.
    function automatic bit plan_event(input int object_id, input logic [15:0] word);
        t_fcd_in event_req;
        int      pair;
        event_req.object_id  = ID_W'(object_id);
        event_req.state_word = word;
        pending_events.push_back(event_req);
        pair = object_id - int'(base_id);
        if (pair < 0 || pair >= STORE_PAIRS)
            return 1'b0;
        planned_state[2 * pair]     = word[7:0];
        planned_state[2 * pair + 1] = word[15:8];
        return 1'b1;
    endfunction

    function automatic logic [15:0] pick_state_word(input logic [15:0] old_word);
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return old_word ^ (16'h0001 << $urandom_range(0, 15));
            2: return old_word ^ 16'($urandom & $urandom & $urandom);
            3: return old_word;
            4: return ~old_word;
            default: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    task automatic add_random_events(input int wanted);
        int          placed;
        int          span;
        int          object_id;
        int          pair;
        logic [15:0] old_word;
        placed = 0;
        span   = (ID_MAX - int'(base_id) < STORE_PAIRS - 1) ? ID_MAX - int'(base_id)
                                                             : STORE_PAIRS - 1;
        while (placed < wanted) begin
            if ($urandom_range(0, 99) < 12) begin
                if (base_id > 0 && $urandom_range(0, 1) != 0)
                    object_id = $urandom_range(0, int'(base_id) - 1);
                else if (int'(base_id) + span < ID_MAX && $urandom_range(0, 1) != 0)
                    object_id = $urandom_range(int'(base_id) + span + 1, ID_MAX);
                else
                    object_id = $urandom_range(0, ID_MAX);
            end else begin
                object_id = int'(base_id) + $urandom_range(0, span);
            end
            pair = object_id - int'(base_id);
            if (pair >= 0 && pair < STORE_PAIRS)
                old_word = {planned_state[2 * pair + 1], planned_state[2 * pair]};
            else
                old_word = 16'($urandom);
            if (plan_event(object_id, pick_state_word(old_word)))
                placed++;
        end
    endtask

    task automatic wait_until_drained();
        do
            @(posedge i_clk);
        while (pending_events.size() != 0 || i_in_valid || expected_changes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input int index, input bit is_write,
                              input logic [APB_DATA_W-1:0] value,
                              output logic [APB_DATA_W-1:0] read_value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= APB_ADDR_W'(index * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        read_value = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (is_write && index == int'(REG_BASE_OBJECT_ID))
            base_id = value[ID_W-1:0];
    endtask

    task automatic check_base_readback();
        logic [APB_DATA_W-1:0] read_value;
        apb_access(int'(REG_BASE_OBJECT_ID), 1'b0, '0, read_value);
        if (read_value[ID_W-1:0] !== base_id) begin
            config_errors++;
            $display("mismatch: base id reads %0d, expected %0d",
                     read_value[ID_W-1:0], base_id);
        end
    endtask

    initial begin
        int                    phase_base [5];
        int                    phase_items [5];
        logic [APB_DATA_W-1:0] unused;
        phase_base  = '{0, ID_MAX, ID_MAX - STORE_PAIRS + 1,
                        $urandom_range(1, ID_MAX - STORE_PAIRS), $urandom_range(0, ID_MAX)};
        phase_items = '{70, 35, 85, 85, 70};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        check_base_readback();
        void'(plan_event(100, 16'h0000));
        void'(plan_event(100, 16'hFFFF));
        void'(plan_event(100, 16'h0000));
        void'(plan_event(100, 16'h0001));
        void'(plan_event(100, 16'h8001));
        void'(plan_event(131, 16'hFFFF));
        void'(plan_event(131, 16'h7FFE));
        void'(plan_event(132, 16'hFFFF));
        void'(plan_event(99, 16'hFFFF));
        void'(plan_event(0, 16'hAAAA));
        void'(plan_event(ID_MAX, 16'h5555));
        void'(plan_event(131, 16'h7FFE));
        void'(plan_event(115, 16'hA55A));
        void'(plan_event(115, 16'h5AA5));
        void'(plan_event(101, 16'h0100));
        void'(plan_event(101, 16'h0000));
        void'(plan_event(116, 16'h00FF));
        void'(plan_event(116, 16'hFF00));
        void'(plan_event(120, 16'h8000));
        void'(plan_event(120, 16'h8000));
        wait_until_drained();

        // Writes to an unmapped register must leave the base id alone.
        apb_access(SPARE_REG, 1'b1, '1, unused);
        check_base_readback();

        for (int p = 0; p < 5; p++) begin
            apb_access(int'(REG_BASE_OBJECT_ID), 1'b1, APB_DATA_W'(phase_base[p]), unused);
            base_settings++;
            check_base_readback();
            if (p == 0)
                stall_request <= 1'b1;
            add_random_events(phase_items[p]);
            wait_until_drained();
        end

        $display("run: %0d events taken, %0d outside the store, %0d pin changes checked",
                 events_accepted, events_dropped, changes_checked);
        $display("run: %0d base id settings, including 0 and %0d", base_settings, ID_MAX);
        if (mismatch_count == 0 && config_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d result mismatches, %0d register errors",
                     mismatch_count, config_errors);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
